// ----- sv/ibrs_pkg.sv -----
// Shared types and constants of the IMU bias removal and smoothing unit.
// Used by the controller, datapath and top level; depends on nothing.
package ibrs_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned LANES      = 6;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned PROD_W     = 51;
  localparam int unsigned IN_DATA_W  = LANES * RAW_W;
  localparam int unsigned OUT_DATA_W = 9 * WORD_W;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_GYRO_SCALE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_SCALE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_ALPHA = 2'd2;

  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 24'd128071;
  localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 24'd4096;
  localparam logic [ALPHA_W-1:0] ALPHA_RST       = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'h10000;

  // last pipeline step: one more than the last lane, drains the write stage
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd6;

  typedef struct packed {
    logic              load;
    logic              pipe_en;
    logic              ema;
    logic [STEP_W-1:0] step;
    logic              clear_bias;
    logic              calc_rate;
    logic              accumulate;
    logic              div_start;
    logic [AXIS_W-1:0] axis;
    logic              bias_wr;
    logic              load_out;
  } ibrs_cmd_t;

  typedef struct packed {
    logic cmd_flag;
    logic div_done;
  } ibrs_sts_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [47:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/ibrs_div.sv -----
// Divider by a constant: multiply by a scaled reciprocal, 17 bits of it per cycle.
// Uses ibrs_pkg; instantiated by the datapath for the bias mean.
module ibrs_div #(
  parameter int unsigned NUM_W   = 41,
  parameter int unsigned DEN_W   = 8,
  parameter int unsigned DIVISOR = 100
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  import ibrs_pkg::*;

  // floor(n / DIVISOR) == floor(n * RECIP / 2^SHIFT) for n below 2^NUM_W
  // as long as DIVISOR is below 2^DEN_W
  localparam int unsigned SHIFT   = NUM_W + DEN_W;
  localparam int unsigned CHUNK_W = 17;
  localparam int unsigned RECIP_W = 3 * CHUNK_W;
  localparam int unsigned PART_W  = NUM_W + CHUNK_W;
  localparam int unsigned ACC_W   = NUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [NUM_W-1:0]   num_q;
  logic [ACC_W-1:0]   acc_q;
  logic [1:0]         cnt_q;
  logic               done_q;
  logic [CHUNK_W-1:0] chunk;
  logic [PART_W-1:0]  part;

  // reciprocal chunks from the top down
  always_comb begin
    case (cnt_q)
      2'd3:    chunk = RECIP[2*CHUNK_W +: CHUNK_W];
      2'd2:    chunk = RECIP[CHUNK_W +: CHUNK_W];
      2'd1:    chunk = RECIP[0 +: CHUNK_W];
      default: chunk = '0;
    endcase
  end

  assign part = num_q * chunk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == 2'd1);
      if (start_i) begin
        cnt_q <= 2'd3;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << CHUNK_W) + ACC_W'(part);
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[SHIFT +: NUM_W];

endmodule

// ----- sv/ibrs_datapath.sv -----
// Datapath: config registers, scaling, bias, filters and the result register.
// Uses ibrs_pkg and ibrs_div; driven by ibrs_ctrl commands.
module ibrs_datapath #(
  parameter int unsigned AVG_SAMPLES = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ibrs_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [ibrs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [ibrs_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic                              in_cmd_i,
  input  ibrs_pkg::ibrs_cmd_t               cmd_i,
  output ibrs_pkg::ibrs_sts_t               sts_o,
  output logic [ibrs_pkg::OUT_DATA_W-1:0]   out_data_o
);
  import ibrs_pkg::*;

  localparam int unsigned NUM_W = SUM_W + 1;

  logic [SCALE_W-1:0] gscale_q, ascale_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic signed [RAW_W-1:0]  raw_q  [LANES];
  logic                     cmd_q;
  logic signed [WORD_W-1:0] scl_q  [LANES];
  logic signed [WORD_W-1:0] rate_q [AXES];
  logic signed [WORD_W-1:0] filt_q [LANES];
  logic signed [WORD_W-1:0] bias_q [AXES];
  logic signed [SUM_W-1:0]  sum_q  [AXES];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [WORD_W-1:0] fcur_q;
  logic [OUT_DATA_W-1:0]    out_q;

  logic [ALPHA_W-1:0]       alpha_eff;
  logic [STEP_W-1:0]        mul_lane, wr_lane, rlane;
  logic signed [RAW_W-1:0]  raw_sel;
  logic [SCALE_W-1:0]       scale_sel;
  logic signed [40:0]       scale_prod;
  logic signed [WORD_W-1:0] ema_x, ema_f;
  logic signed [32:0]       ema_diff;
  logic signed [PROD_W-1:0] ema_prod;
  logic signed [PROD_W-1:0] scl_round, ema_sum;
  logic signed [WORD_W-1:0] scl_val, ema_val;
  logic                     mul_en, wr_en;

  logic signed [SUM_W-1:0]  sum_sel;
  logic                     sum_neg;
  logic [SUM_W-1:0]         mag;
  logic [NUM_W-1:0]         num, quot;
  logic signed [47:0]       mean_ext;
  logic signed [WORD_W-1:0] mean_val;
  logic                     div_done;

  assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign mul_en    = cmd_i.pipe_en && (cmd_i.step != LAST_STEP);
  assign wr_en     = cmd_i.pipe_en && (cmd_i.step != '0);
  assign mul_lane  = (cmd_i.step != LAST_STEP) ? cmd_i.step : '0;
  assign wr_lane   = (cmd_i.step != '0) ? cmd_i.step - STEP_W'(1) : '0;
  assign rlane     = (mul_lane >= STEP_W'(AXES)) ? mul_lane - STEP_W'(AXES) : '0;

  assign raw_sel    = raw_q[mul_lane];
  assign scale_sel  = (mul_lane < STEP_W'(AXES)) ? ascale_q : gscale_q;
  assign scale_prod = raw_sel * $signed({1'b0, scale_sel});

  // lanes 0-2 smooth the accelerometer, lanes 3-5 the corrected gyro
  assign ema_x    = (mul_lane < STEP_W'(AXES)) ? scl_q[mul_lane] : rate_q[rlane[AXIS_W-1:0]];
  assign ema_f    = filt_q[mul_lane];
  assign ema_diff = 33'(ema_x) - 33'(ema_f);
  assign ema_prod = $signed({1'b0, alpha_eff}) * ema_diff;

  assign scl_round = prod_q + 51'sd128;
  assign scl_val   = scl_round[39:8];
  assign ema_sum   = (PROD_W'(fcur_q) <<< 16) + prod_q + 51'sd32768;
  assign ema_val   = sat32(48'($signed(ema_sum[PROD_W-1:16])));

  assign sum_sel  = sum_q[cmd_i.axis];
  assign sum_neg  = sum_sel[SUM_W-1];
  assign mag      = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign num      = {1'b0, mag} + NUM_W'(AVG_SAMPLES / 2);
  assign mean_ext = sum_neg ? -$signed(48'(quot)) : $signed(48'(quot));
  assign mean_val = sat32(mean_ext);

  ibrs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (CNT_W),
    .DIVISOR(AVG_SAMPLES)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gscale_q <= GYRO_SCALE_RST;
      ascale_q <= ACCEL_SCALE_RST;
      alpha_q  <= ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_GYRO_SCALE:   gscale_q <= cfg_wdata_i;
        CFG_ACCEL_SCALE:  ascale_q <= cfg_wdata_i;
        CFG_SMOOTH_ALPHA: alpha_q  <= cfg_wdata_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      for (int i = 0; i < LANES; i++) begin
        raw_q[i] <= in_data_i[i*RAW_W +: RAW_W];
      end
    end
    if (mul_en) begin
      prod_q <= cmd_i.ema ? ema_prod : PROD_W'(scale_prod);
      fcur_q <= ema_f;
    end
    if (wr_en && !cmd_i.ema) begin
      scl_q[wr_lane] <= scl_val;
    end
    if (cmd_i.calc_rate) begin
      for (int i = 0; i < AXES; i++) begin
        rate_q[i] <= sat32(48'(scl_q[AXES + i]) - 48'(bias_q[i]));
      end
    end
    if (cmd_i.load_out) begin
      out_q <= {filt_q[2], filt_q[1], filt_q[0], filt_q[5], filt_q[4], filt_q[3],
                rate_q[2], rate_q[1], rate_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        filt_q[i] <= '0;
      end
      for (int i = 0; i < AXES; i++) begin
        bias_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else begin
      if (wr_en && cmd_i.ema) begin
        filt_q[wr_lane] <= ema_val;
      end
      if (cmd_i.clear_bias) begin
        for (int i = 0; i < AXES; i++) begin
          bias_q[i] <= '0;
          sum_q[i]  <= '0;
        end
      end
      if (cmd_i.accumulate) begin
        for (int i = 0; i < AXES; i++) begin
          sum_q[i] <= sum_q[i] + SUM_W'(scl_q[AXES + i]);
        end
      end
      if (cmd_i.bias_wr) begin
        bias_q[cmd_i.axis] <= mean_val;
      end
    end
  end

  assign sts_o.cmd_flag = cmd_q;
  assign sts_o.div_done = div_done;
  assign out_data_o     = out_q;

endmodule

// ----- sv/ibrs_ctrl.sv -----
// Controller: item sequencing, calibration counters and stream handshakes.
// Uses ibrs_pkg; commands ibrs_datapath.
module ibrs_ctrl #(
  parameter int unsigned SETTLE_SAMPLES = 50,
  parameter int unsigned AVG_SAMPLES    = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_cal_o,
  input  ibrs_pkg::ibrs_sts_t  sts_i,
  output ibrs_pkg::ibrs_cmd_t  cmd_o
);
  import ibrs_pkg::*;

  localparam logic [CNT_W-1:0] SETTLE_C = CNT_W'(SETTLE_SAMPLES);
  localparam logic [CNT_W-1:0] AVG_C    = CNT_W'(AVG_SAMPLES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_CMD, ST_RATE, ST_EMA, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [AXIS_W-1:0] axis_q;
  logic [CNT_W-1:0]  count_q, count_inc;
  logic              active_q, phase_q, cal_q, out_valid_q, out_cal_q;
  logic              out_free;

  assign count_inc = count_q + CNT_W'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = step_q;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE:     cmd_o.load = in_valid_i;
      ST_SCALE:    cmd_o.pipe_en = 1'b1;
      ST_CMD:      cmd_o.clear_bias = sts_i.cmd_flag;
      ST_RATE: begin
        cmd_o.calc_rate  = 1'b1;
        cmd_o.accumulate = active_q && phase_q;
      end
      ST_EMA: begin
        cmd_o.pipe_en = 1'b1;
        cmd_o.ema     = 1'b1;
      end
      ST_DIV_GO:   cmd_o.div_start = 1'b1;
      ST_DIV_WAIT: cmd_o.bias_wr = sts_i.div_done;
      ST_OUT:      cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      count_q     <= '0;
      active_q    <= 1'b0;
      phase_q     <= 1'b0;
      cal_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_cal_q   <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_valid_i) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (step_q == LAST_STEP) begin
            state_q <= ST_CMD;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_CMD: begin
          if (sts_i.cmd_flag) begin
            count_q  <= '0;
            active_q <= 1'b1;
            phase_q  <= (SETTLE_SAMPLES == 0);
          end
          state_q <= ST_RATE;
        end
        ST_RATE: begin
          cal_q  <= active_q;
          step_q <= '0;
          axis_q <= '0;
          if (!active_q) begin
            state_q <= ST_EMA;
          end else if (!phase_q) begin
            state_q <= ST_OUT;
            if (count_inc >= SETTLE_C) begin
              phase_q <= 1'b1;
              count_q <= '0;
            end else begin
              count_q <= count_inc;
            end
          end else if (count_inc >= AVG_C) begin
            active_q <= 1'b0;
            phase_q  <= 1'b0;
            count_q  <= '0;
            state_q  <= ST_DIV_GO;
          end else begin
            count_q <= count_inc;
            state_q <= ST_OUT;
          end
        end
        ST_EMA: begin
          if (step_q == LAST_STEP) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_DIV_GO: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (sts_i.div_done) begin
            if (axis_q == AXIS_W'(AXES - 1)) begin
              state_q <= ST_OUT;
            end else begin
              axis_q  <= axis_q + AXIS_W'(1);
              state_q <= ST_DIV_GO;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_cal_q <= cal_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_cal_o   = out_cal_q;

endmodule

// ----- sv/imu_bias_removal_smoother_unit.sv -----
// Top level of the IMU bias removal and smoothing unit.
// Depends on ibrs_pkg, ibrs_ctrl, ibrs_datapath (and ibrs_div below it).
//
// Usage:
// - Slave stream carries one six-axis raw sample per transfer; tuser high
//   clears the gyro bias and starts calibration with that sample.
// - Master stream returns one result per sample: corrected rates, smoothed
//   rates, smoothed acceleration, all Q16.16; tuser is the calibrating flag.
// - Config writes (gyro scale, accel scale, alpha) only while idle.
// Flow:
// - A sample goes from the input transfer to a valid result through the
//   shared scaling multiplier over six lanes, then bias handling, then the
//   shared filter multiplier over six lanes, then the result load.
// - Samples taken while calibrating skip the filters; the sample that closes
//   a calibration runs the reciprocal-multiply mean divider once per axis.
// - One sample in work at a time; tready is high while the unit is idle,
//   so a new sample is taken only once the last result has been loaded.
// Reset clears bias, filters and calibration state and loads the register
// defaults. A stalled receiver holds the result register; the next sample is
// still taken and processed, then waits until the held result is transferred.
module imu_bias_removal_smoother_unit #(
  parameter int unsigned SETTLE_SAMPLES = 50,
  parameter int unsigned AVG_SAMPLES    = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ibrs_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [ibrs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // acc_raw_x, acc_raw_y, acc_raw_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
  input  logic [ibrs_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // cmd
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // rate_x/y/z, rate_smooth_x/y/z, accel_smooth_x/y/z
  output logic [ibrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // calibrating
  output logic                             m_axis_tuser_o
);
  import ibrs_pkg::*;

  ibrs_cmd_t cmd;
  ibrs_sts_t sts;

  ibrs_ctrl #(
    .SETTLE_SAMPLES(SETTLE_SAMPLES),
    .AVG_SAMPLES   (AVG_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_cal_o  (m_axis_tuser_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ibrs_datapath #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata_i),
    .in_cmd_i   (s_axis_tuser_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o)
  );

endmodule
